[rtl/core/atlc_pkg.sv]
package atlc_pkg;

  // Phase codes as seen on green_dir
  typedef enum logic [1:0] {
    DIR_WALK = 2'd0,
    DIR_HOR  = 2'd1,
    DIR_STR  = 2'd2
  } dir_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_CLAMP,
    ST_UPD
  } state_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_FLOW_STRAIGHT   = 3'd0;
  localparam logic [2:0] CFG_FLOW_HORIZONTAL = 3'd1;
  localparam logic [2:0] CFG_WALK_LIMIT      = 3'd2;
  localparam logic [2:0] CFG_MIN_GREEN       = 3'd3;
  localparam logic [2:0] CFG_MAX_GREEN       = 3'd4;
  localparam logic [2:0] CFG_WALK_TICKS      = 3'd5;

  localparam int CFG_W = 12;

  // Reset values
  localparam logic [7:0]  FLOW_RST       = 8'd1;
  localparam logic [11:0] WALK_LIMIT_RST = 12'd80;
  localparam logic [3:0]  MIN_GREEN_RST  = 4'd3;
  localparam logic [3:0]  MAX_GREEN_RST  = 4'd9;
  localparam logic [3:0]  WALK_TICKS_RST = 4'd3;
  localparam int          QS_RST         = 100;
  localparam int          QH_RST         = 20;

endpackage

[rtl/core/atlc_div.sv]
module atlc_div #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [7:0]   divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic         rem_nz
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       dsr_r, dsr_nxt;
  logic [8:0]       rem_sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, dvd_r[W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign done   = busy_r && (cnt_r == CNT_W'(W));
  assign quot   = dvd_r;
  assign rem_nz = rem_r != 8'd0;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = 8'd0;
      dsr_nxt  = divisor;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      dvd_nxt = {dvd_r[W-2:0], ge};
      rem_nxt = ge ? 8'(rem_sh - {1'b0, dsr_r}) : rem_sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

[rtl/core/adaptive_traffic_light_controller_top.sv]
// Path from input transfer to result: ST_IDLE, ST_DECIDE, ST_UPD when no green time
// is computed, ST_CLAMP before ST_UPD when the excess is zero, and ST_DIV then ST_CLAMP
// when the divider runs (one quotient bit per cycle); ST_UPD waits on out_tready.
// in_tready is high only in the idle state; the result sits in an output register.
// Reset (rst_n low, synchronous) loads the register defaults and the phase,
// countdown and congestion reset values; no clearing pass.
module adaptive_traffic_light_controller_top #(
  parameter int JAM_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [0] ped_request
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,
  // out_tdata: [1:0] green_dir, [5:2] time_left, jam_straight, jam_horizontal,
  // walk_granted, zero fill
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*JAM_BITS+7+7)/8)*8-1:0]      out_tdata,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_addr,
  input  logic [atlc_pkg::CFG_W-1:0]             cfg_wdata
);

  import atlc_pkg::*;

  localparam int J     = JAM_BITS;
  localparam int OUT_W = ((2*JAM_BITS+7+7)/8)*8;
  localparam int CW    = (JAM_BITS > CFG_W) ? JAM_BITS : CFG_W;
  localparam logic [J-1:0] JAM_MAX = {J{1'b1}};

  // configuration registers
  logic [7:0]  flow_s_r, flow_h_r;
  logic [11:0] walk_limit_r;
  logic [3:0]  min_green_r, max_green_r, walk_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_s_r     <= FLOW_RST;
      flow_h_r     <= FLOW_RST;
      walk_limit_r <= WALK_LIMIT_RST;
      min_green_r  <= MIN_GREEN_RST;
      max_green_r  <= MAX_GREEN_RST;
      walk_ticks_r <= WALK_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FLOW_STRAIGHT:   flow_s_r     <= cfg_wdata[7:0];
        CFG_FLOW_HORIZONTAL: flow_h_r     <= cfg_wdata[7:0];
        CFG_WALK_LIMIT:      walk_limit_r <= cfg_wdata[11:0];
        CFG_MIN_GREEN:       min_green_r  <= cfg_wdata[3:0];
        CFG_MAX_GREEN:       max_green_r  <= cfg_wdata[3:0];
        CFG_WALK_TICKS:      walk_ticks_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // controller state
  state_t       state_r, state_nxt;
  dir_t         phase_r, phase_nxt;
  logic [3:0]   cd_r, cd_nxt;
  logic [J-1:0] qs_r, qs_nxt, qh_r, qh_nxt;
  logic         pend_r, pend_nxt, grant_r, grant_nxt;
  logic [J:0]   t_r, t_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // fsm outputs
  logic in_xfer, div_start, out_load;

  // divider
  logic         div_done, div_rem_nz;
  logic [J-1:0] div_quot, ex;
  logic [7:0]   div_dsr;

  atlc_div #(.W(J)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ex),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // decision terms
  logic [J-1:0] bigger, avg, jam_g;
  logic [J:0]   qsum;
  logic [7:0]   flow_o;
  dir_t         newdir;
  logic         excess;

  assign bigger = (qs_r > qh_r) ? qs_r : qh_r;
  assign qsum   = {1'b0, qs_r} + {1'b0, qh_r};
  assign avg    = qsum[J:1];

  always_comb begin
    case (phase_r)
      DIR_HOR: newdir = DIR_STR;
      DIR_STR: newdir = DIR_HOR;
      default: newdir = (qh_r > qs_r) ? DIR_STR : DIR_HOR;  // after walk
    endcase
  end

  assign jam_g   = (newdir == DIR_STR) ? qs_r : qh_r;
  assign flow_o  = (newdir == DIR_STR) ? flow_h_r : flow_s_r;
  assign div_dsr = (flow_o == 8'd0) ? 8'd1 : flow_o;   // zero flow divides as 1
  assign excess  = jam_g > avg;
  assign ex      = jam_g - avg;

  // congestion update
  function automatic logic [J-1:0] sat_add(input logic [J-1:0] q, input logic [7:0] f);
    logic [J:0] s;
    s = {1'b0, q} + (J+1)'(f);
    return s[J] ? JAM_MAX : s[J-1:0];
  endfunction

  function automatic logic [J-1:0] drain(input logic [J-1:0] q, input logic [7:0] f);
    logic [J:0] d;
    d = (J+1)'(f) + (J+1)'(1);
    return ({1'b0, q} > d) ? J'({1'b0, q} - d) : '0;
  endfunction

  logic [J-1:0] qs_upd, qh_upd;
  logic [J:0]   t_lo;

  always_comb begin
    case (phase_r)
      DIR_STR: begin
        qs_upd = drain(qs_r, flow_s_r);
        qh_upd = sat_add(qh_r, flow_h_r);
      end
      DIR_HOR: begin
        qs_upd = sat_add(qs_r, flow_s_r);
        qh_upd = drain(qh_r, flow_h_r);
      end
      default: begin
        qs_upd = sat_add(qs_r, flow_s_r);
        qh_upd = sat_add(qh_r, flow_h_r);
      end
    endcase
  end

  // raise to min, then cap at max (max wins)
  assign t_lo = (t_r < (J+1)'(min_green_r)) ? (J+1)'(min_green_r) : t_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (cd_r != 4'd0 || grant_r) state_nxt = ST_UPD;
        else if (excess)             state_nxt = ST_DIV;
        else                         state_nxt = ST_CLAMP;
      end
      ST_DIV:    if (div_done) state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_UPD;
      ST_UPD:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_DECIDE) && (cd_r == 4'd0) && !grant_r && excess;
    out_load  = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  end

  assign in_xfer = in_tvalid && in_tready;

  // datapath
  always_comb begin
    phase_nxt     = phase_r;
    cd_nxt        = cd_r;
    qs_nxt        = qs_r;
    qh_nxt        = qh_r;
    pend_nxt      = pend_r;
    grant_nxt     = grant_r;
    t_nxt         = t_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_xfer) begin
      // press absorbed while a grant waits; grant when both roads are light
      if ((in_tdata[0] && !grant_r) || pend_r) begin
        if (CW'(bigger) <= CW'(walk_limit_r)) begin
          grant_nxt = 1'b1;
          pend_nxt  = 1'b0;
        end else begin
          pend_nxt  = 1'b1;
        end
      end
    end

    if (state_r == ST_DECIDE && cd_r == 4'd0) begin
      if (grant_r) begin
        phase_nxt = DIR_WALK;
        cd_nxt    = walk_ticks_r;
        grant_nxt = 1'b0;
      end else begin
        phase_nxt = newdir;
        t_nxt     = '0;
      end
    end

    if (state_r == ST_DIV && div_done) t_nxt = {1'b0, div_quot} + (J+1)'(div_rem_nz);

    if (state_r == ST_CLAMP)
      cd_nxt = (t_lo > (J+1)'(max_green_r)) ? max_green_r : 4'(t_lo);

    if (out_load) begin
      qs_nxt        = qs_upd;
      qh_nxt        = qh_upd;
      if (cd_r != 4'd0) cd_nxt = cd_r - 4'd1;
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({grant_r, qh_upd, qs_upd, cd_r, phase_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= DIR_HOR;
      cd_r        <= 4'd0;
      qs_r        <= J'(QS_RST);
      qh_r        <= J'(QH_RST);
      pend_r      <= 1'b0;
      grant_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cd_r        <= cd_nxt;
      qs_r        <= qs_nxt;
      qh_r        <= qh_nxt;
      pend_r      <= pend_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
